// File: hdl/sghg_pkg.sv
// shared types, constants and point arithmetic of the strip ghost hit generator
package sghg_pkg;

  localparam int MaxHits      = 8;
  localparam int MaxResults   = 64;
  localparam int ResCntW      = $clog2(MaxResults + 1);
  localparam int VaneCountW   = 7;
  localparam int KeyW         = 10;

  localparam logic [VaneCountW-1:0] VaneCountReset = 7'd48;

  localparam logic [11:0]        RMin  = 12'd750;
  localparam logic [11:0]        RMax  = 12'd2949;
  localparam logic signed [11:0] ZMin  = -12'sd1999;
  localparam logic signed [11:0] ZMax  = 12'sd2000;

  // column and row boundaries after mm truncation
  localparam logic [11:0]        RCol1 = 12'd1300;
  localparam logic [11:0]        RCol2 = 12'd1850;
  localparam logic [11:0]        RCol3 = 12'd2400;
  localparam logic signed [11:0] ZRow1 = 12'sd1009;
  localparam logic signed [11:0] ZRow2 = 12'sd9;
  localparam logic signed [11:0] ZRow3 = -12'sd1000;

  typedef struct packed {
    logic [11:0]        r_tenths;
    logic signed [11:0] z_tenths;
    logic [5:0]         vane_index;
    logic               last_hit;
  } hit_t;

  typedef struct packed {
    logic [5:0]         vane_out;
    logic [3:0]         unit_out;
    logic [11:0]        r_out;
    logic signed [11:0] z_out;
    logic               is_ghost;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic [5:0]        vane;
    logic [3:0]        unit;
    logic [8:0]        strip_r;
    logic signed [9:0] strip_z;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [3:0] {
    StIdle,
    StScanRd,
    StScanChk,
    StJRd,
    StJChk,
    StKRd,
    StKChk,
    StEmit,
    StFlush
  } walk_state_e;

  // radius of the inner edge of a column
  function automatic logic [11:0] col_base(input logic [1:0] col);
    logic [11:0] res;
    unique case (col)
      2'd0: res = 12'd750;
      2'd1: res = 12'd1300;
      2'd2: res = 12'd1850;
      default: res = 12'd2400;
    endcase
    return res;
  endfunction

  // z of the upper edge of a row
  function automatic logic signed [12:0] row_base(input logic [1:0] row);
    logic signed [12:0] res;
    unique case (row)
      2'd0: res = 13'sd2000;
      2'd1: res = 13'sd1000;
      2'd2: res = 13'sd0;
      default: res = -13'sd1000;
    endcase
    return res;
  endfunction

  function automatic result_t make_point(input logic [5:0] vane, input logic [3:0] unit,
                                         input logic [8:0] sr, input logic signed [9:0] sz,
                                         input logic ghost);
    result_t            res;
    logic signed [12:0] zt;
    zt = row_base(unit[3:2]) - $signed({{2{sz[9]}}, sz, 1'b1});
    res.vane_out    = vane;
    res.unit_out    = unit;
    res.r_out       = col_base(unit[1:0]) + {2'b00, sr, 1'b1};
    res.z_out       = zt[11:0];
    res.is_ghost    = ghost;
    res.last_result = 1'b0;
    return res;
  endfunction

endpackage

// File: hdl/sghg_hit_if.sv
// hit channel: valid, ready and one hit word
interface sghg_hit_if;
  logic          valid;
  logic          ready;
  sghg_pkg::hit_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/sghg_result_if.sv
// result channel: valid, ready and one result word
interface sghg_result_if;
  logic             valid;
  logic             ready;
  sghg_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/sghg_cfg_if.sv
// configuration write channel carrying the vane count word
interface sghg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sghg_pkg::VaneCountW-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/strip_ghost_hit_generator_core.sv
// top level of the strip ghost hit generator
// A hit that is not the last of its event is taken and its strip centre leaves
// at once through the output register, so hits stream at one per cycle while
// the result side keeps up. The last hit starts a walk over the hit memory
// through its single read port, with a read state and a check state per entry
// read: each group of equal vane and unit is found by a scan of all H stored
// hits, and a group with m > 1 members gets an outer pass plus an inner pass
// for each member, emitting its ghosts on the way. A last scan that finds no
// further group comes before a final flush, unless the event already reached
// its result limit. Hits are taken again once the last result of the event
// leaves the output register. The vane count is written over its own channel;
// the user must write it only between events, which the block does not enforce.
module strip_ghost_hit_generator_core #(
  parameter int MAX_HITS = sghg_pkg::MaxHits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sghg_hit_if.sink      hit_i,
  sghg_result_if.source result_o,
  sghg_cfg_if.sink      cfg_i
);

  logic [sghg_pkg::VaneCountW-1:0] vane_count_q;
  sghg_pkg::entry_t                entry;
  logic                            ram_we;
  logic [$clog2(MAX_HITS)-1:0]     ram_waddr;
  logic [sghg_pkg::EntryW-1:0]     ram_wdata;
  logic                            ram_re;
  logic [$clog2(MAX_HITS)-1:0]     ram_raddr;
  logic [sghg_pkg::EntryW-1:0]     ram_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vane_count_q <= sghg_pkg::VaneCountReset;
    end else if (cfg_i.valid) begin
      vane_count_q <= cfg_i.data;
    end
  end

  sghg_hit_map u_hit_map (
    .hit_i   (hit_i.data),
    .entry_o (entry)
  );

  sghg_ram #(
    .WIDTH (sghg_pkg::EntryW),
    .DEPTH (MAX_HITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sghg_walk #(
    .MAX_HITS (MAX_HITS)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hit_i        (hit_i),
    .result_o     (result_o),
    .entry_i      (entry),
    .vane_count_i (vane_count_q),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

endmodule

// File: hdl/sghg_ram.sv
// generic single write port ram with registered read
module sghg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/sghg_hit_map.sv
// maps a hit to its detector unit and strip indices
module sghg_hit_map (
  input  sghg_pkg::hit_t   hit_i,
  output sghg_pkg::entry_t entry_o
);

  logic [11:0]        r_sat;
  logic signed [11:0] z_sat;
  logic [1:0]         col;
  logic [1:0]         row;
  logic [11:0]        r_diff;
  logic signed [12:0] z_diff;
  logic signed [12:0] z_adj;

  always_comb begin
    if (hit_i.r_tenths < sghg_pkg::RMin) begin
      r_sat = sghg_pkg::RMin;
    end else if (hit_i.r_tenths > sghg_pkg::RMax) begin
      r_sat = sghg_pkg::RMax;
    end else begin
      r_sat = hit_i.r_tenths;
    end

    if (hit_i.z_tenths < sghg_pkg::ZMin) begin
      z_sat = sghg_pkg::ZMin;
    end else if (hit_i.z_tenths > sghg_pkg::ZMax) begin
      z_sat = sghg_pkg::ZMax;
    end else begin
      z_sat = hit_i.z_tenths;
    end

    if (r_sat >= sghg_pkg::RCol3) begin
      col = 2'd3;
    end else if (r_sat >= sghg_pkg::RCol2) begin
      col = 2'd2;
    end else if (r_sat >= sghg_pkg::RCol1) begin
      col = 2'd1;
    end else begin
      col = 2'd0;
    end

    if (z_sat <= sghg_pkg::ZRow3) begin
      row = 2'd3;
    end else if (z_sat <= sghg_pkg::ZRow2) begin
      row = 2'd2;
    end else if (z_sat <= sghg_pkg::ZRow1) begin
      row = 2'd1;
    end else begin
      row = 2'd0;
    end

    r_diff = r_sat - sghg_pkg::col_base(col);
    z_diff = sghg_pkg::row_base(row) - 13'(z_sat);
    // halve toward zero
    z_adj  = z_diff + $signed({12'd0, z_diff[12]});

    entry_o.vane    = hit_i.vane_index;
    entry_o.unit    = {row, col};
    entry_o.strip_r = r_diff[9:1];
    entry_o.strip_z = z_adj[10:1];
  end

endmodule

// File: hdl/sghg_walk.sv
// hit loading, ghost pair walk over the hit memory and output buffering
module sghg_walk #(
  parameter int MAX_HITS = sghg_pkg::MaxHits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sghg_hit_if.sink                            hit_i,
  sghg_result_if.source                       result_o,
  input  sghg_pkg::entry_t                    entry_i,
  input  logic [sghg_pkg::VaneCountW-1:0]     vane_count_i,
  output logic                                ram_we_o,
  output logic [$clog2(MAX_HITS)-1:0]         ram_waddr_o,
  output logic [sghg_pkg::EntryW-1:0]         ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(MAX_HITS)-1:0]         ram_raddr_o,
  input  logic [sghg_pkg::EntryW-1:0]         ram_rdata_i
);

  localparam int IdxW = $clog2(MAX_HITS);
  localparam int CntW = $clog2(MAX_HITS + 1);

  sghg_pkg::walk_state_e state_q, state_d;
  logic [CntW-1:0]                 hc_q, hc_d;
  logic [CntW-1:0]                 j_q, j_d;
  logic [CntW-1:0]                 k_q, k_d;
  logic [sghg_pkg::KeyW-1:0]       cur_key_q, cur_key_d;
  logic [sghg_pkg::KeyW-1:0]       prev_key_q, prev_key_d;
  logic                            have_prev_q, have_prev_d;
  logic                            found_q, found_d;
  logic [sghg_pkg::KeyW-1:0]       best_key_q, best_key_d;
  logic [1:0]                      best_cnt_q, best_cnt_d;
  logic [8:0]                      sr_j_q, sr_j_d;
  logic [sghg_pkg::ResCntW-1:0]    n_q, n_d;
  logic                            out_valid_q, out_valid_d;
  sghg_pkg::result_t               out_q, out_d;
  sghg_pkg::result_t               pend_q, pend_d;

  sghg_pkg::entry_t                rd_entry;
  sghg_pkg::result_t               real_res;
  logic [sghg_pkg::KeyW-1:0]       rd_key;
  logic                            out_free;
  logic                            accept;
  logic                            store;

  assign rd_entry = sghg_pkg::entry_t'(ram_rdata_i);
  assign rd_key   = {rd_entry.vane, rd_entry.unit};
  assign real_res = sghg_pkg::make_point(entry_i.vane, entry_i.unit, entry_i.strip_r,
                                         entry_i.strip_z, 1'b0);
  assign out_free = !out_valid_q || result_o.ready;
  assign hit_i.ready = (state_q == sghg_pkg::StIdle) && out_free;
  assign accept   = hit_i.valid && hit_i.ready;
  assign store    = hc_q < CntW'(MAX_HITS);

  assign ram_we_o    = accept && store;
  assign ram_waddr_o = hc_q[IdxW-1:0];
  assign ram_wdata_o = sghg_pkg::EntryW'(entry_i);
  assign ram_re_o    = (state_q == sghg_pkg::StScanRd) || (state_q == sghg_pkg::StJRd) ||
                       (state_q == sghg_pkg::StKRd);
  assign ram_raddr_o = (state_q == sghg_pkg::StKRd) ? k_q[IdxW-1:0] : j_q[IdxW-1:0];

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sghg_pkg::StIdle;
      hc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hc_q        <= hc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    k_q         <= k_d;
    cur_key_q   <= cur_key_d;
    prev_key_q  <= prev_key_d;
    have_prev_q <= have_prev_d;
    found_q     <= found_d;
    best_key_q  <= best_key_d;
    best_cnt_q  <= best_cnt_d;
    sr_j_q      <= sr_j_d;
    n_q         <= n_d;
    out_q       <= out_d;
    pend_q      <= pend_d;
  end

  always_comb begin
    logic                      elig;
    logic                      found_n;
    logic [sghg_pkg::KeyW-1:0] best_n;
    logic [1:0]                cnt_n;
    logic                      next_k;
    logic                      next_j;

    state_d     = state_q;
    hc_d        = hc_q;
    j_d         = j_q;
    k_d         = k_q;
    cur_key_d   = cur_key_q;
    prev_key_d  = prev_key_q;
    have_prev_d = have_prev_q;
    found_d     = found_q;
    best_key_d  = best_key_q;
    best_cnt_d  = best_cnt_q;
    sr_j_d      = sr_j_q;
    n_d         = n_q;
    out_d       = out_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !result_o.ready;
    elig        = 1'b0;
    found_n     = found_q;
    best_n      = best_key_q;
    cnt_n       = best_cnt_q;
    next_k      = 1'b0;
    next_j      = 1'b0;

    unique case (state_q)
      sghg_pkg::StIdle: begin
        if (accept) begin
          if (store) begin
            hc_d = hc_q + 1'b1;
          end
          if (hit_i.data.last_hit) begin
            pend_d      = real_res;
            n_d         = sghg_pkg::ResCntW'(1);
            j_d         = '0;
            have_prev_d = 1'b0;
            found_d     = 1'b0;
            best_cnt_d  = '0;
            state_d     = sghg_pkg::StScanRd;
          end else begin
            out_d       = real_res;
            out_valid_d = 1'b1;
          end
        end
      end
      sghg_pkg::StScanRd: begin
        state_d = sghg_pkg::StScanChk;
      end
      sghg_pkg::StScanChk: begin
        // smallest eligible key above the previous group
        elig = ({1'b0, rd_entry.vane} < vane_count_i) && (!have_prev_q || rd_key > prev_key_q);
        if (elig) begin
          if (!found_q || rd_key < best_key_q) begin
            found_n = 1'b1;
            best_n  = rd_key;
            cnt_n   = 2'd1;
          end else if (rd_key == best_key_q) begin
            cnt_n   = 2'd2;
          end
        end
        found_d    = found_n;
        best_key_d = best_n;
        best_cnt_d = cnt_n;
        if (j_q + 1'b1 == hc_q) begin
          j_d = '0;
          if (!found_n) begin
            state_d = sghg_pkg::StFlush;
          end else if (!cnt_n[1]) begin
            prev_key_d  = best_n;
            have_prev_d = 1'b1;
            found_d     = 1'b0;
            best_cnt_d  = '0;
            state_d     = sghg_pkg::StScanRd;
          end else begin
            cur_key_d = best_n;
            state_d   = sghg_pkg::StJRd;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = sghg_pkg::StScanRd;
        end
      end
      sghg_pkg::StJRd: begin
        state_d = sghg_pkg::StJChk;
      end
      sghg_pkg::StJChk: begin
        if (rd_key == cur_key_q) begin
          sr_j_d  = rd_entry.strip_r;
          k_d     = '0;
          state_d = sghg_pkg::StKRd;
        end else begin
          next_j = 1'b1;
        end
      end
      sghg_pkg::StKRd: begin
        state_d = sghg_pkg::StKChk;
      end
      sghg_pkg::StKChk: begin
        if (rd_key == cur_key_q && k_q != j_q) begin
          state_d = sghg_pkg::StEmit;
        end else begin
          next_k = 1'b1;
        end
      end
      sghg_pkg::StEmit: begin
        if (out_free) begin
          out_d             = pend_q;
          out_d.last_result = 1'b0;
          out_valid_d       = 1'b1;
          pend_d = sghg_pkg::make_point(cur_key_q[9:4], cur_key_q[3:0], sr_j_q,
                                        rd_entry.strip_z, 1'b1);
          n_d = n_q + 1'b1;
          if (n_q == sghg_pkg::ResCntW'(sghg_pkg::MaxResults - 1)) begin
            state_d = sghg_pkg::StFlush;
          end else begin
            next_k = 1'b1;
          end
        end
      end
      sghg_pkg::StFlush: begin
        if (out_free) begin
          out_d             = pend_q;
          out_d.last_result = 1'b1;
          out_valid_d       = 1'b1;
          hc_d              = '0;
          state_d           = sghg_pkg::StIdle;
        end
      end
      default: begin
        state_d = sghg_pkg::StIdle;
      end
    endcase

    if (next_k) begin
      if (k_q + 1'b1 == hc_q) begin
        next_j = 1'b1;
      end else begin
        k_d     = k_q + 1'b1;
        state_d = sghg_pkg::StKRd;
      end
    end

    if (next_j) begin
      if (j_q + 1'b1 == hc_q) begin
        // group done, look for the next one
        prev_key_d  = cur_key_q;
        have_prev_d = 1'b1;
        found_d     = 1'b0;
        best_cnt_d  = '0;
        j_d         = '0;
        state_d     = sghg_pkg::StScanRd;
      end else begin
        j_d     = j_q + 1'b1;
        state_d = sghg_pkg::StJRd;
      end
    end
  end

endmodule

// File: tb/strip_ghost_hit_generator_core_tb.sv
// self-checking testbench: random hit events against a strip and ghost point predictor
`timescale 1ns / 100ps

module strip_ghost_hit_generator_core_tb;

  localparam int StallLimit = 20000;
  localparam int SegItems   = 30;

  class ghost_scoreboard;
    logic [sghg_pkg::VaneCountW-1:0] vane_count;
    int                              stored;
    int                              st_vane[sghg_pkg::MaxHits];
    int                              st_unit[sghg_pkg::MaxHits];
    int                              st_sr[sghg_pkg::MaxHits];
    int                              st_sz[sghg_pkg::MaxHits];
    sghg_pkg::result_t               points_q[$];
    int                              mismatches;

    function new();
      vane_count = sghg_pkg::VaneCountReset;
      stored     = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return points_q.size();
    endfunction

    function sghg_pkg::result_t strip_point(int vane, int unit, int sr, int sz, bit ghost);
      sghg_pkg::result_t p;
      int                r;
      int                z;
      r = 750 + 550 * (unit % 4) + 2 * sr + 1;
      z = 2000 - 1000 * (unit / 4) - (2 * sz + 1);
      p.vane_out    = 6'(vane);
      p.unit_out    = 4'(unit);
      p.r_out       = 12'(r);
      p.z_out       = 12'(z);
      p.is_ghost    = ghost;
      p.last_result = 1'b0;
      return p;
    endfunction

    function void add_point(sghg_pkg::result_t p);
      points_q.insert(points_q.size(), p);
    endfunction

    function void note_hit(sghg_pkg::hit_t h);
      int r, z, col, row, unit, sr, sz;
      int v, u, j, k, cnt, produced;
      r = h.r_tenths;
      z = h.z_tenths;
      if (r < 750) r = 750;
      if (r > 2949) r = 2949;
      if (z < -1999) z = -1999;
      if (z > 2000) z = 2000;
      col = (r / 10 - 75) / 55;
      row = (200 - z / 10) / 100;
      if (col > 3) col = 3;
      if (row > 3) row = 3;
      unit = col + 4 * row;
      sr   = (r - 750 - 550 * col) / 2;
      sz   = (2000 - z - 1000 * row) / 2;
      add_point(strip_point(h.vane_index, unit, sr, sz, 1'b0));
      produced = 1;
      if (stored < sghg_pkg::MaxHits) begin
        st_vane[stored] = h.vane_index;
        st_unit[stored] = unit;
        st_sr[stored]   = sr;
        st_sz[stored]   = sz;
        stored++;
      end
      if (h.last_hit) begin
        for (v = 0; v < 64 && v < vane_count; v++) begin
          for (u = 0; u < 16; u++) begin
            cnt = 0;
            for (j = 0; j < stored; j++)
              if (st_vane[j] == v && st_unit[j] == u) cnt++;
            if (cnt < 2) continue;
            for (j = 0; j < stored; j++) begin
              if (st_vane[j] != v || st_unit[j] != u) continue;
              for (k = 0; k < stored; k++) begin
                if (k == j || st_vane[k] != v || st_unit[k] != u) continue;
                if (produced < sghg_pkg::MaxResults) begin
                  add_point(strip_point(v, u, st_sr[j], st_sz[k], 1'b1));
                  produced++;
                end
              end
            end
          end
        end
        points_q[points_q.size() - 1].last_result = 1'b1;
        stored = 0;
      end
    endfunction

    task report(string msg);
      if (mismatches < 200) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, int want, int got);
      if (want != got) report($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    task check_point(sghg_pkg::result_t got);
      sghg_pkg::result_t want;
      if (points_q.size() == 0) begin
        report($sformatf("unexpected word vane %0d unit %0d r %0d z %0d",
                         got.vane_out, got.unit_out, got.r_out, got.z_out));
      end else begin
        want = points_q.pop_front();
        compare_field("vane_out", want.vane_out, got.vane_out);
        compare_field("unit_out", want.unit_out, got.unit_out);
        compare_field("r_out", want.r_out, got.r_out);
        compare_field("z_out", want.z_out, got.z_out);
        compare_field("is_ghost", want.is_ghost, got.is_ghost);
        compare_field("last_result", want.last_result, got.last_result);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  sghg_hit_if    hit_ch ();
  sghg_result_if res_ch ();
  sghg_cfg_if    cfg_ch ();

  strip_ghost_hit_generator_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .hit_i    (hit_ch),
    .result_o (res_ch),
    .cfg_i    (cfg_ch)
  );

  ghost_scoreboard sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int items_sent;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      res_ch.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.vane_count = cfg_ch.data;
      if (hit_ch.valid && hit_ch.ready) sb.note_hit(hit_ch.data);
      if (res_ch.valid && res_ch.ready) sb.check_point(res_ch.data);
      if ((cfg_ch.valid && cfg_ch.ready) || (hit_ch.valid && hit_ch.ready) ||
          (res_ch.valid && res_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("strip_ghost_hit_generator_core_tb: FAIL");
        $finish;
      end
    end
  end

  function sghg_pkg::hit_t make_hit(int r, int z, int v, bit last);
    sghg_pkg::hit_t h;
    h.r_tenths   = 12'(r);
    h.z_tenths   = 12'(z);
    h.vane_index = 6'(v);
    h.last_hit   = last;
    return h;
  endfunction

  function int r_in_col(int c);
    int lo;
    int hi;
    lo = 750 + 550 * c;
    hi = (c == 3) ? 2949 : lo + 549;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function int z_in_row(int row);
    int lo;
    int hi;
    case (row)
      0: begin lo = 1010; hi = 2000; end
      1: begin lo = 10; hi = 1009; end
      2: begin lo = -999; hi = 9; end
      default: begin lo = -1999; hi = -1000; end
    endcase
    // strips just above the row's upper edge come out negative
    if (row == 2 && $urandom_range(0, 4) == 0) begin
      lo = -9;
      hi = 9;
    end
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task send_hit(sghg_pkg::hit_t h);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      hit_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    hit_ch.valid <= 1'b1;
    hit_ch.data  <= h;
    @(posedge clk_i);
    while (!hit_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task send_event();
    int  n_hits, n_groups, pick, lim, g, i;
    int  g_vane[3];
    int  g_unit[3];
    bit  clustered;
    bit  last;
    pick      = $urandom_range(0, 99);
    n_hits    = (pick < 15) ? 1 : (pick < 85) ? $urandom_range(2, 8) : $urandom_range(9, 11);
    clustered = ($urandom_range(0, 99) < 75);
    lim       = (sb.vane_count == 0 || sb.vane_count > 64) ? 64 : sb.vane_count;
    n_groups  = $urandom_range(1, 3);
    for (g = 0; g < 3; g++) begin
      g_vane[g] = ($urandom_range(0, 9) < 8) ? $urandom_range(0, lim - 1) : $urandom_range(0, 63);
      g_unit[g] = $urandom_range(0, 15);
    end
    for (i = 0; i < n_hits; i++) begin
      last = (i == n_hits - 1);
      if (clustered && $urandom_range(0, 9) != 0) begin
        g = $urandom_range(0, n_groups - 1);
        send_hit(make_hit(r_in_col(g_unit[g] % 4), z_in_row(g_unit[g] / 4), g_vane[g], last));
      end else begin
        send_hit(make_hit($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 63), last));
      end
    end
  endtask

  task wait_results_done();
    hit_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task write_vane_count(logic [sghg_pkg::VaneCountW-1:0] val);
    wait_results_done();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [sghg_pkg::VaneCountW-1:0] vc_list[6];
    int                              seg;
    int                              i;
    int                              start;
    rst_ni       = 1'b0;
    hit_ch.valid = 1'b0;
    hit_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    res_ch.ready = 1'b0;
    rx_hold      = 0;
    items_sent   = 0;
    stall_cycles = 0;
    tx_idle_pct  = 36;
    rx_idle_pct  = 81;
    vc_list      = '{7'd1, 7'd64, 7'd127, 7'd0, 7'($urandom_range(2, 63)), 7'd48};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // more hits than storage, all in one unit of vane 0
    for (i = 0; i < 10; i++) send_hit(make_hit(r_in_col(1), z_in_row(1), 0, i == 9));
    // saturation, field extremes, negative strip, unit edges
    send_hit(make_hit(0, -2048, 63, 1'b0));
    send_hit(make_hit(4095, 2047, 0, 1'b0));
    send_hit(make_hit(2949, 9, 5, 1'b0));
    send_hit(make_hit(2400, -9, 5, 1'b0));
    send_hit(make_hit(1299, 1009, 6, 1'b0));
    send_hit(make_hit(1300, 1010, 6, 1'b0));
    send_hit(make_hit(750, -1000, 0, 1'b1));
    // pairs on both sides of the vane count
    send_hit(make_hit(1000, 500, 47, 1'b0));
    send_hit(make_hit(1010, 510, 47, 1'b0));
    send_hit(make_hit(1000, 500, 48, 1'b0));
    send_hit(make_hit(1010, 510, 48, 1'b1));

    for (seg = 0; seg < 6; seg++) begin
      write_vane_count(vc_list[seg]);
      if (seg < 2) begin
        tx_idle_pct = 36;
        rx_idle_pct = 81;
      end else if (seg < 4) begin
        tx_idle_pct = 81;
        rx_idle_pct = 36;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (seg == 0) rx_hold = 400;
      start = items_sent;
      while (items_sent - start < SegItems) send_event();
    end

    wait_results_done();
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("strip_ghost_hit_generator_core_tb: PASS");
    end else begin
      $display("strip_ghost_hit_generator_core_tb: FAIL");
    end
    $finish;
  end

endmodule
